/* rtl/frt_pkg.sv */
package frt_pkg;

  // frame geometry
  localparam int MAX_CHUNKS = 16;
  localparam int SLOT_W     = $clog2(MAX_CHUNKS);
  localparam int EXP_W      = $clog2(MAX_CHUNKS + 1);
  localparam int MASK_W     = 16;
  localparam int LEN_W      = 11;
  localparam int BYTES_W    = 16;
  localparam int STORED_W   = 7;

  localparam logic [LEN_W-1:0]    PAYLOAD_LIMIT   = LEN_W'(1500);
  localparam logic [STORED_W-1:0] STORED_MAX      = '1;
  localparam logic [BYTES_W-1:0]  MAX_BYTES_RESET = BYTES_W'(16384);
  localparam logic signed [15:0]  MAX_CHUNKS_S    = 16'(MAX_CHUNKS);

  // result codes
  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_DUP       = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NO_FRAME  = 3'd4,
    ST_DESC      = 3'd5,
    ST_TOO_LARGE = 3'd6,
    ST_MISSING   = 3'd7
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RES,
    S_WALK,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic walk_fail;
    logic walk_adv;
    logic load_result;
    logic load_desc;
    logic desc_adv;
    logic frame_clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ignore;
    logic walk_need;
    logic slot_empty;
    logic too_big;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/frt_ctrl.sv */
module frt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  frt_pkg::sts_t sts,
  output frt_pkg::cmd_t cmd
);
  import frt_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.ignore) begin
          state_next = S_IDLE;
        end else if (sts.walk_need) begin
          state_next = S_WALK;
        end else begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.slot_empty || sts.too_big) begin
          cmd.walk_fail = 1'b1;
          state_next    = S_RES;
        end else begin
          cmd.walk_adv = 1'b1;
          if (sts.walk_last) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_desc = 1'b1;
          cmd.desc_adv  = 1'b1;
          if (sts.walk_last) begin
            cmd.frame_clr = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/frt_dp.sv */
module frt_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  frt_pkg::cmd_t                cmd,
  output frt_pkg::sts_t                sts,
  input  logic                         cfg_valid,
  input  logic [frt_pkg::BYTES_W-1:0]  cfg_data,
  input  logic [31:0]                  frag_id,
  input  logic signed [15:0]           frag_index,
  input  logic signed [15:0]           frag_count,
  input  logic [frt_pkg::LEN_W-1:0]    payload_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic                         dropped_previous,
  output logic [frt_pkg::MASK_W-1:0]   missing_mask,
  output logic [3:0]                   chunk_index,
  output logic [frt_pkg::BYTES_W-1:0]  chunk_offset,
  output logic [frt_pkg::LEN_W-1:0]    chunk_length,
  output logic [frt_pkg::BYTES_W-1:0]  frame_length,
  output logic                         last
);
  import frt_pkg::*;

  // captured request
  logic [31:0]        id_q;
  logic signed [15:0] idx_q;
  logic signed [15:0] cnt_q;
  logic [LEN_W-1:0]   len_q;

  // frame state
  logic [31:0]         active_id;
  logic [EXP_W-1:0]    exp_total;
  logic [STORED_W-1:0] stored_total;
  logic [LEN_W-1:0]    slot_len [MAX_CHUNKS];
  logic [BYTES_W-1:0]  max_bytes;

  // per-request result state
  status_t             res_status;
  logic                drop;
  logic [MASK_W-1:0]   mask;
  logic [SLOT_W-1:0]   walk_cnt;
  logic [BYTES_W-1:0]  total;
  logic [BYTES_W-1:0]  offset;

  // decode of the captured request
  logic                cnt_bad;
  logic                idx_bad;
  logic                hdr_ok;
  logic                id_diff;
  logic                frame_open;
  logic                start;
  logic                foreign;
  logic                drop_now;
  logic [EXP_W-1:0]    exp_after;
  logic [SLOT_W-1:0]   slot;
  logic                in_range;
  logic [SLOT_W-1:0]   rd_addr;
  logic [LEN_W-1:0]    rd_len;
  logic                slot_was_empty;
  logic                do_store;
  logic [STORED_W-1:0] stored_base;
  logic [STORED_W-1:0] stored_after;
  logic [MASK_W-1:0]   mask_now;
  status_t             ev_status;
  logic [BYTES_W:0]    sum_ext;

  assign cnt_bad    = (cnt_q <= 16'sd0) || (cnt_q > MAX_CHUNKS_S);
  assign idx_bad    = (idx_q < 16'sd0) || (idx_q >= cnt_q);
  assign hdr_ok     = !sts.ignore && !cnt_bad && !idx_bad;
  assign id_diff    = id_q != active_id;
  assign frame_open = exp_total != '0;
  assign start      = (idx_q == 16'sd0) && (!frame_open || id_diff);
  assign foreign    = (idx_q != 16'sd0) && frame_open && id_diff;
  assign drop_now   = (start && frame_open && (stored_total < STORED_W'(exp_total))) || foreign;
  assign slot       = idx_q[SLOT_W-1:0];
  assign in_range   = EXP_W'(slot) < exp_after;

  always_comb begin
    if (start) begin
      exp_after = cnt_q[EXP_W-1:0];
    end else if (foreign) begin
      exp_after = '0;
    end else begin
      exp_after = exp_total;
    end
  end

  // single slot read port, header slot while deciding, walk counter otherwise
  assign rd_addr = cmd.eval ? slot : walk_cnt;
  assign rd_len  = slot_len[rd_addr];

  assign slot_was_empty = start || (rd_len == '0);
  assign do_store       = hdr_ok && (exp_after != '0) && in_range && slot_was_empty;
  assign stored_base    = start ? '0 : stored_total;
  assign stored_after   = (do_store && stored_base != STORED_MAX) ? stored_base + 1'b1
                                                                  : stored_base;

  // empty slots of the frame in progress
  always_comb begin
    mask_now = '0;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      if ((EXP_W'(i) < exp_total) && (slot_len[i] == '0)) begin
        mask_now[i] = 1'b1;
      end
    end
  end

  // result code of a request that does not complete the frame
  always_comb begin
    if (cnt_bad) begin
      ev_status = ST_BAD_COUNT;
    end else if (idx_bad) begin
      ev_status = ST_BAD_INDEX;
    end else if (exp_after == '0) begin
      ev_status = ST_NO_FRAME;
    end else if (!in_range) begin
      ev_status = ST_BAD_INDEX;
    end else if (slot_was_empty) begin
      ev_status = ST_STORED;
    end else begin
      ev_status = ST_DUP;
    end
  end

  assign sum_ext = {1'b0, total} + (BYTES_W + 1)'(rd_len);

  // status toward the controller
  always_comb begin
    sts.ignore     = len_q > PAYLOAD_LIMIT;
    sts.walk_need  = do_store || (hdr_ok && (exp_after != '0) && in_range);
    sts.walk_need  = sts.walk_need && (stored_after >= STORED_W'(exp_after));
    sts.slot_empty = rd_len == '0;
    sts.too_big    = sum_ext > {1'b0, max_bytes};
    sts.walk_last  = (EXP_W'(walk_cnt) + 1'b1) == exp_total;
    sts.out_free   = !out_valid || out_ready;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_valid) begin
      max_bytes <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_q  <= frag_id;
      idx_q <= frag_index;
      cnt_q <= frag_count;
      len_q <= payload_length;
    end
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active_id    <= '0;
      exp_total    <= '0;
      stored_total <= '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        slot_len[i] <= '0;
      end
    end else if (cmd.frame_clr) begin
      exp_total    <= '0;
      stored_total <= '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        slot_len[i] <= '0;
      end
    end else if (cmd.eval && hdr_ok) begin
      if (start || foreign) begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
          slot_len[i] <= '0;
        end
      end
      if (start) begin
        active_id <= id_q;
      end
      exp_total    <= exp_after;
      stored_total <= foreign ? '0 : stored_after;
      if (do_store) begin
        slot_len[slot] <= len_q;
      end
    end
  end

  // result state, walk counter and running sums
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_status <= ev_status;
      drop       <= hdr_ok && drop_now;
      mask       <= (hdr_ok && drop_now) ? mask_now : '0;
      walk_cnt   <= '0;
      total      <= '0;
      offset     <= '0;
    end else begin
      if (cmd.walk_fail) begin
        res_status <= sts.slot_empty ? ST_MISSING : ST_TOO_LARGE;
      end
      if (cmd.walk_adv) begin
        total    <= sum_ext[BYTES_W-1:0];
        walk_cnt <= sts.walk_last ? '0 : walk_cnt + 1'b1;
      end
      if (cmd.desc_adv) begin
        offset   <= offset + BYTES_W'(rd_len);
        walk_cnt <= sts.walk_last ? '0 : walk_cnt + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result || cmd.load_desc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status           <= res_status;
      dropped_previous <= drop;
      missing_mask     <= mask;
      chunk_index      <= '0;
      chunk_offset     <= '0;
      chunk_length     <= '0;
      frame_length     <= '0;
      last             <= 1'b1;
    end else if (cmd.load_desc) begin
      status           <= ST_DESC;
      dropped_previous <= drop;
      missing_mask     <= mask;
      chunk_index      <= 4'(walk_cnt);
      chunk_offset     <= offset;
      chunk_length     <= rd_len;
      frame_length     <= total;
      last             <= sts.walk_last;
    end
  end

endmodule

/* rtl/fragment_reassembly_tracker.sv */
// Fragment reassembly tracker: follows one multi-fragment message from
// decoded fragment headers and reports per-fragment results.
// Input channel (in_valid/in_ready): one header request per transfer
// (frag_id, frag_index, frag_count, payload_length).
// Output channel (out_valid/out_ready): result items; last marks the final
// result of a request. A completing fragment yields one descriptor per chunk.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes max_frame_bytes, always
// ready, write only while no request is in flight.
// Sequence: a single-result request passes accept, evaluate and result load,
// then the next request is taken; an oversized payload gives no result and
// returns to idle after evaluate. A completing fragment is evaluated, then a
// walk checks its chunk lengths (one slot read per cycle through the shared
// slot read port); an empty slot or too many bytes gives one result instead of
// descriptors. One request is processed at a time; the output register lets
// the next request be accepted while the final result still waits.
// Reset (rst, synchronous): no frame open, all slots empty, active id zero,
// max_frame_bytes = 16384. When the receiver stalls, results hold in the
// output register and the controller waits before loading the next one.
module fragment_reassembly_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  frag_id,
  input  logic signed [15:0]           frag_index,
  input  logic signed [15:0]           frag_count,
  input  logic [frt_pkg::LEN_W-1:0]    payload_length,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [frt_pkg::BYTES_W-1:0]  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic                         dropped_previous,
  output logic [frt_pkg::MASK_W-1:0]   missing_mask,
  output logic [3:0]                   chunk_index,
  output logic [frt_pkg::BYTES_W-1:0]  chunk_offset,
  output logic [frt_pkg::LEN_W-1:0]    chunk_length,
  output logic [frt_pkg::BYTES_W-1:0]  frame_length,
  output logic                         last
);
  import frt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencing
  frt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // frame state, slot store and output register
  frt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .frag_id          (frag_id),
    .frag_index       (frag_index),
    .frag_count       (frag_count),
    .payload_length   (payload_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .dropped_previous (dropped_previous),
    .missing_mask     (missing_mask),
    .chunk_index      (chunk_index),
    .chunk_offset     (chunk_offset),
    .chunk_length     (chunk_length),
    .frame_length     (frame_length),
    .last             (last)
  );

endmodule
